// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file fcmp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fcmp_pkg.sv -----
package fcmp_pkg;

   // Longest field (header, code or checksum) in bytes
   localparam int FIELD_LEN = 4;
   // Field counter must hold FIELD_LEN + 1
   localparam int CNT_W = $clog2(FIELD_LEN + 2);
   localparam int HDR_LEN = 3;

   localparam logic [7:0] CH_START = 8'h24;  // '$'
   localparam logic [7:0] CH_SEP   = 8'h2A;  // '*'
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] MAX_CODE_RESET = 8'd197;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_CODE   = 2'd2,
      PH_CHECK  = 2'd3
   } phase_type;

   // Input stage contents handed to the parser
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } stage_type;

   // Expected header "E03", by position
   function automatic logic [7:0] hdr_char(input logic [CNT_W-1:0] pos);
      logic [7:0] ch;
      case (pos)
         CNT_W'(0): ch = 8'h45;  // 'E'
         CNT_W'(1): ch = 8'h30;  // '0'
         CNT_W'(2): ch = 8'h33;  // '3'
         default:   ch = 8'h00;
      endcase
      return ch;
   endfunction

   // acc * 10 + digit, mod 256
   function automatic logic [7:0] mul10_add(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] d;
      d = b - CH_ZERO;
      return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + d;
   endfunction

endpackage

// ----- rtl/fcmp_in_reg.sv -----
module fcmp_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                advance,
   output fcmp_pkg::stage_type stage
);
   import fcmp_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       take;

   // Stage frees up whenever its byte moves on
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_data_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.data_byte = data_ff;

endmodule

// ----- rtl/fcmp_core.sv -----
module fcmp_core (
   input  logic                clock,
   input  logic                reset,
   input  fcmp_pkg::stage_type stage,
   output logic                advance,
   input  logic                csr_write,
   input  logic [7:0]          csr_max_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_accepted_code
);
   import fcmp_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             match_ff, match_in;
   logic [7:0]       hsum_ff, hsum_in;
   logic [7:0]       code_ff, code_in;
   logic [7:0]       chk_ff, chk_in;
   logic             ended_ff, ended_in;
   logic [7:0]       max_code_ff, max_code_in;
   logic             rvalid_ff, rvalid_in;
   logic [7:0]       rcode_ff, rcode_in;

   logic             fire;
   logic [7:0]       b;
   logic [CNT_W-1:0] cnt_inc;
   logic             overflow;
   logic             is_digit;
   logic             code_ok;
   logic             sum_ok;
   logic [7:0]       frame_sum;
   logic [7:0]       result;

   // Output register is free or being drained
   assign advance = !rvalid_ff || rsp_ready;
   assign fire    = stage.valid && advance;
   assign b       = stage.data_byte;

   // Shared decode of the current byte
   assign cnt_inc   = count_ff + CNT_W'(1);
   assign overflow  = cnt_inc > CNT_W'(FIELD_LEN);
   assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
   assign code_ok   = (code_ff != 8'd0) && (code_ff <= max_code_ff);
   assign frame_sum = hsum_ff + CH_START + CH_SEP + CH_SEP + chk_ff + code_ff;
   assign sum_ok    = frame_sum == 8'd0;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_IDLE: begin
               if (b == CH_START) phase_in = PH_HEADER;
            end
            PH_HEADER: begin
               if (b != CH_SEP) begin
                  if (overflow) phase_in = PH_IDLE;
               end else if (match_ff && count_ff == CNT_W'(HDR_LEN)) begin
                  phase_in = PH_CODE;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CODE: begin
               if (b != CH_SEP) begin
                  if (overflow) phase_in = PH_IDLE;
               end else if (code_ok) begin
                  phase_in = PH_CHECK;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CHECK: begin
               if (b != CH_CR) begin
                  if (overflow) phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Field accumulators and result
   always_comb begin
      count_in = count_ff;
      match_in = match_ff;
      hsum_in  = hsum_ff;
      code_in  = code_ff;
      chk_in   = chk_ff;
      ended_in = ended_ff;
      result   = 8'd0;
      if (fire) begin
         case (phase_ff)
            PH_IDLE: begin
               count_in = '0;
               match_in = 1'b1;
               hsum_in  = 8'd0;
               code_in  = 8'd0;
               chk_in   = 8'd0;
               ended_in = 1'b0;
            end
            PH_HEADER: begin
               if (b != CH_SEP) begin
                  if (count_ff >= CNT_W'(HDR_LEN) || hdr_char(count_ff) != b)
                     match_in = 1'b0;
                  hsum_in  = hsum_ff + b;
                  count_in = cnt_inc;
               end else begin
                  count_in = '0;
                  ended_in = 1'b0;
               end
            end
            PH_CODE: begin
               if (b != CH_SEP) begin
                  count_in = cnt_inc;
                  if (!overflow && !ended_ff) begin
                     if (is_digit) code_in = mul10_add(code_ff, b);
                     else          ended_in = 1'b1;
                  end
               end else begin
                  count_in = '0;
                  ended_in = 1'b0;
               end
            end
            PH_CHECK: begin
               if (b != CH_CR) begin
                  count_in = cnt_inc;
                  if (!overflow && !ended_ff) begin
                     if (is_digit) chk_in = mul10_add(chk_ff, b);
                     else          ended_in = 1'b1;
                  end
               end else if (sum_ok) begin
                  result = code_ff;
               end
            end
            default: result = 8'd0;
         endcase
      end
   end

   // Result register and config register
   always_comb begin
      rvalid_in = rvalid_ff;
      rcode_in  = rcode_ff;
      if (fire) begin
         rvalid_in = 1'b1;
         rcode_in  = result;
      end else if (rsp_ready) begin
         rvalid_in = 1'b0;
      end
      max_code_in = csr_write ? csr_max_code : max_code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         count_ff    <= '0;
         match_ff    <= 1'b1;
         hsum_ff     <= 8'd0;
         code_ff     <= 8'd0;
         chk_ff      <= 8'd0;
         ended_ff    <= 1'b0;
         max_code_ff <= MAX_CODE_RESET;
         rvalid_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         match_ff    <= match_in;
         hsum_ff     <= hsum_in;
         code_ff     <= code_in;
         chk_ff      <= chk_in;
         ended_ff    <= ended_in;
         max_code_ff <= max_code_in;
         rvalid_ff   <= rvalid_in;
      end
      rcode_ff <= rcode_in;
   end

   assign rsp_valid         = rvalid_ff;
   assign rsp_accepted_code = rcode_ff;

endmodule

// ----- rtl/framed_code_message_parser.sv -----
// Framed code message parser: one received byte per transaction on the
// req_ channel, frames of the form '$' "E03" '*' code '*' checksum CR.
// Every byte gives exactly one transaction on the rsp_ channel:
// rsp_accepted_code is the frame's code on a CR that closes a valid frame
// (header correct, code in 1..max_code, byte sum check zero), else 0.
// csr_ writes the max_code register; csr_ready is always high. Write it
// only while no byte is in flight.
// Path: a byte accepted on req_ goes through the input register, then the
// parser state and result register, before its result shows on rsp_.
// Throughput: one byte per cycle while the receiver takes results; the
// parser state update is combinational, so bytes stream back to back.
// When the receiver stalls the result register holds, the input register
// fills next, and req_ready drops only when both are full; nothing is
// dropped. req_ready follows rsp_ready combinationally.
// Synchronous reset empties both registers, puts the parser in idle
// waiting for '$' and sets max_code to 197.
module framed_code_message_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_accepted_code,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_code
);
   import fcmp_pkg::*;

   stage_type stage;
   logic      advance;

   assign csr_ready = 1'b1;

   fcmp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .stage         (stage)
   );

   fcmp_core u_core (
      .clock             (clock),
      .reset             (reset),
      .stage             (stage),
      .advance           (advance),
      .csr_write         (csr_valid && csr_ready),
      .csr_max_code      (csr_max_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted_code (rsp_accepted_code)
   );

endmodule

// ----- rtl/fcmp_checker.sv -----
`include "assert_macros.svh"

module fcmp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready
);

   // A stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped while stalled")

   // Reset leaves no result pending
   `ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result pending after reset")

   // With the output empty the input side never stalls
   `ASSERT_CLK(a_no_stall, clock, reset, !rsp_valid |-> req_ready, "req_ready low with empty output")

   // A fresh result comes from a byte accepted on req_ and held in the input register
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "result without a byte")

endmodule

bind framed_code_message_parser fcmp_checker u_fcmp_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
   import fcmp_pkg::*;

   localparam logic [23:0] HDR_WORD         = "E03";
   localparam int          SENDER           = 0;
   localparam int          RECEIVER         = 1;
   localparam int          HOLD_CYCLES      = 80;
   localparam int          RANDOM_PER_PHASE = 250;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte     = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [7:0] rsp_accepted_code;
   logic       csr_valid         = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_max_code      = 8'h00;

   // bytes still to be offered on the req_ channel
   logic [7:0] stim_q[$];
   // zero-wait stretch left per side
   int         calm_left[2];

   framed_code_message_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted_code (rsp_accepted_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_code      (csr_max_code)
   );

   // Frame parser prediction plus queue of expected codes
   class code_scoreboard;
      phase_type  parse_phase;
      logic [3:0] field_cnt;
      logic       hdr_ok;
      logic       num_done;
      logic [7:0] hdr_sum;
      logic [7:0] code_acc;
      logic [7:0] chk_acc;
      logic [7:0] code_limit;
      logic [7:0] expected_codes[$];
      int         errors;

      function new();
         code_limit  = MAX_CODE_RESET;
         parse_phase = PH_IDLE;
         errors      = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         field_cnt = '0;
         hdr_ok    = 1'b1;
         hdr_sum   = '0;
         code_acc  = '0;
         chk_acc   = '0;
         num_done  = 1'b0;
      endfunction

      // one more byte in the field; too many sends the parser back to idle
      function bit count_byte();
         field_cnt = field_cnt + 4'd1;
         if (field_cnt > FIELD_LEN) begin
            parse_phase = PH_IDLE;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // decimal accumulate; the first non-digit freezes the number
      function logic [7:0] next_digit(logic [7:0] acc, logic [7:0] b);
         if (num_done)
            return acc;
         if (b >= CH_ZERO && b <= CH_NINE)
            return acc * 8'd10 + (b - CH_ZERO);
         num_done = 1'b1;
         return acc;
      endfunction

      // accepted transaction on req_: advance the parser, queue its result
      function void note_byte(logic [7:0] b);
         logic [7:0] sum;
         logic [7:0] code;
         int         pos;
         code = 8'h00;
         case (parse_phase)
            PH_IDLE: begin
               clear_frame();
               if (b == CH_START)
                  parse_phase = PH_HEADER;
            end
            PH_HEADER: begin
               if (b != CH_SEP) begin
                  pos = int'(field_cnt);
                  if (pos >= HDR_LEN)
                     hdr_ok = 1'b0;
                  else if (HDR_WORD[8*(HDR_LEN-1-pos) +: 8] != b)
                     hdr_ok = 1'b0;
                  hdr_sum = hdr_sum + b;
                  void'(count_byte());
               end else if (hdr_ok && field_cnt == HDR_LEN) begin
                  parse_phase = PH_CODE;
                  field_cnt   = '0;
                  num_done    = 1'b0;
               end else begin
                  parse_phase = PH_IDLE;
               end
            end
            PH_CODE: begin
               if (b != CH_SEP) begin
                  if (count_byte())
                     code_acc = next_digit(code_acc, b);
               end else if (code_acc >= 8'd1 && code_acc <= code_limit) begin
                  parse_phase = PH_CHECK;
                  field_cnt   = '0;
                  num_done    = 1'b0;
               end else begin
                  parse_phase = PH_IDLE;
               end
            end
            PH_CHECK: begin
               if (b != CH_CR) begin
                  if (count_byte())
                     chk_acc = next_digit(chk_acc, b);
               end else begin
                  sum = hdr_sum + CH_START + CH_SEP + CH_SEP + chk_acc + code_acc;
                  parse_phase = PH_IDLE;
                  if (sum == 8'h00)
                     code = code_acc;
               end
            end
         endcase
         expected_codes.push_back(code);
      endfunction

      // accepted transaction on rsp_: compare with the oldest expectation
      function void check_code(logic [7:0] got);
         logic [7:0] want;
         if (expected_codes.size() == 0) begin
            $error("accepted_code: unexpected transaction, actual %0d", got);
            errors++;
            return;
         end
         want = expected_codes.pop_front();
         if (got !== want) begin
            $error("accepted_code: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   code_scoreboard sb;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("** framed_code_message_parser: FAILED **");
      $finish;
   end

   // wait count per transaction, with occasional stretches of no waiting
   function automatic int draw_wait(int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left[side] = $urandom_range(15, 50);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // checksum value that makes a well-formed "E03" frame pass
   function automatic int check_for(int code);
      int s;
      s = HDR_WORD[23:16] + HDR_WORD[15:8] + HDR_WORD[7:0] + CH_START + 2 * CH_SEP + code;
      return (256 - s % 256) % 256;
   endfunction

   function automatic string dec(int v);
      return $sformatf("%0d", v);
   endfunction

   function automatic logic [7:0] filler();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEP || b == CH_CR);
      return b;
   endfunction

   function automatic void push_text(string s);
      foreach (s[i])
         stim_q.push_back(s[i]);
   endfunction

   function automatic void push_fixed(string hdr, string code_txt, string chk_txt);
      stim_q.push_back(CH_START);
      push_text(hdr);
      stim_q.push_back(CH_SEP);
      push_text(code_txt);
      stim_q.push_back(CH_SEP);
      push_text(chk_txt);
      stim_q.push_back(CH_CR);
   endfunction

   // number field worth v mod 256: plain, wrapped, zero padded,
   // trailed by junk, or empty for zero
   function automatic void push_num(int v);
      string s;
      int    sel;
      int    pad;
      sel = $urandom_range(0, 4);
      if (sel == 4 && v == 0)
         return;
      if (sel == 1)
         v = v + 256 * $urandom_range(1, (10 ** FIELD_LEN - 1 - v) / 256);
      s = dec(v);
      if (sel == 2) begin
         pad = $urandom_range(s.len(), FIELD_LEN);
         while (s.len() < pad)
            s = {"0", s};
      end
      push_text(s);
      if (sel == 3 && s.len() < FIELD_LEN) begin
         stim_q.push_back(filler());
         repeat ($urandom_range(0, FIELD_LEN - 1 - s.len()))
            stim_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void push_random_frame(logic [7:0] limit);
      int sel;
      int code;
      int chk;
      int start;
      int pos;
      sel   = $urandom_range(0, 99);
      start = stim_q.size();
      if (sel >= 85) begin
         // line noise between frames
         repeat ($urandom_range(1, 4))
            stim_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (sel < 65) begin
         code = (limit == 0) ? $urandom_range(1, 255) : $urandom_range(1, limit);
         if ($urandom_range(0, 15) == 0 && check_for(0) <= limit)
            code = check_for(0);
      end else if (sel < 75) begin
         if (limit == 8'd255 || $urandom_range(0, 1) == 0)
            code = 0;
         else
            code = $urandom_range(limit + 1, 255);
      end else begin
         code = $urandom_range(0, 255);
      end
      chk = check_for(code);
      if ($urandom_range(0, 7) == 0)
         chk = (chk + $urandom_range(1, 255)) % 256;
      stim_q.push_back(CH_START);
      push_text("E03");
      stim_q.push_back(CH_SEP);
      push_num(code);
      stim_q.push_back(CH_SEP);
      push_num(chk);
      stim_q.push_back(CH_CR);
      // broken frame: one byte replaced, or cut short
      if (sel >= 75) begin
         pos = $urandom_range(start, stim_q.size() - 1);
         if ($urandom_range(0, 1) == 0) begin
            stim_q[pos] = 8'($urandom_range(0, 255));
         end else begin
            while (stim_q.size() > pos)
               void'(stim_q.pop_back());
         end
      end
   endfunction

   function automatic void fill_random(int n);
      int start;
      start = stim_q.size();
      while (stim_q.size() - start < n)
         push_random_frame(sb.code_limit);
   endfunction

   // frames with the code at the limit and just above it
   function automatic void push_edge_frames(logic [7:0] limit);
      if (limit >= 8'd1)
         push_fixed("E03", dec(limit), dec(check_for(limit)));
      if (limit < 8'd255)
         push_fixed("E03", dec(limit + 1), dec(check_for(limit + 1)));
   endfunction

   // offer every queued byte; called and returns at a falling edge
   task automatic send_bytes();
      int gap;
      while (stim_q.size() != 0) begin
         gap = draw_wait(SENDER);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= stim_q[0];
         do @(posedge clock); while (!req_ready);
         sb.note_byte(stim_q.pop_front());
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.expected_codes.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(logic [7:0] v);
      csr_max_code <= v;
      csr_valid    <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.code_limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: random stalls, plus long hold-offs that back up the input
   initial begin : receiver
      int wait_cycles;
      int results_seen;
      results_seen = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         wait_cycles = draw_wait(RECEIVER);
         if (results_seen == 500 || results_seen == 1100)
            wait_cycles = HOLD_CYCLES;
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_code(rsp_accepted_code);
         results_seen++;
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin
      logic [7:0] limit_steps[5];
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes outside a frame each give a zero result
      stim_q.push_back(8'h00);
      stim_q.push_back(8'hFF);
      stim_q.push_back(CH_SEP);
      stim_q.push_back(CH_CR);
      // smallest code, zero code, empty code
      push_fixed("E03", "1", dec(check_for(1)));
      push_fixed("E03", "0", dec(check_for(0)));
      push_fixed("E03", "", "32");
      // code that wraps to 1, junk inside both numbers
      push_fixed("E03", "0257", dec(check_for(1)));
      push_fixed("E03", "7x9", {dec(check_for(7)), "q"});
      // wrong checksum, checksum that wraps
      push_fixed("E03", "5", dec((check_for(5) + 1) % 256));
      push_fixed("E03", "9", dec(check_for(9) + 256 * 30));
      // bad, short, long and overlong headers
      push_fixed("E04", "5", dec(check_for(5)));
      push_fixed("E0", "5", dec(check_for(5)));
      push_fixed("E03E", "5", dec(check_for(5)));
      push_fixed("E03EE", "5", dec(check_for(5)));
      // overlong code and checksum fields
      push_fixed("E03", "12345", "0");
      push_fixed("E03", "5", "12345");
      push_edge_frames(sb.code_limit);
      fill_random(RANDOM_PER_PHASE);
      send_bytes();

      limit_steps = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 254)), MAX_CODE_RESET};
      foreach (limit_steps[i]) begin
         wait_drained();
         write_limit(limit_steps[i]);
         push_edge_frames(limit_steps[i]);
         // code whose checksum is zero, sent with an empty checksum field
         if (limit_steps[i] == 8'd255)
            push_fixed("E03", dec(check_for(0)), "");
         fill_random(RANDOM_PER_PHASE);
         send_bytes();
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (sb.errors == 0)
         $display("** framed_code_message_parser: PASSED **");
      else
         $display("** framed_code_message_parser: FAILED **");
      $finish;
   end

endmodule
